/* rtl/tev_pkg.sv */
package tev_pkg;

  localparam int unsigned WORD_W           = 32;
  localparam int unsigned CNT_W            = 6;
  localparam int unsigned MAX_CHANNELS_DEF = 32;

  // Buffer word type codes in bits 26:24.
  localparam logic [2:0] TYPE_DATUM  = 3'd0;
  localparam logic [2:0] TYPE_HEADER = 3'd2;
  localparam logic [2:0] TYPE_EOB    = 3'd4;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRATE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT    = 2'd2;

  localparam int unsigned CRATE_W = 5;
  localparam int unsigned SLOT_W  = 5;

  // Added to the channel count in the record header word.
  localparam int unsigned TRAILER_ADD = 3;

  // Record command queue; the depth is a power of two so pointers wrap.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [CNT_W-1:0] count_t;

  typedef struct packed {
    logic              en;
    logic              bank;
    count_t            idx;
    logic [WORD_W-1:0] data;
  } buf_wr_t;

  typedef struct packed {
    logic              bank;
    count_t            count;
    logic [WORD_W-1:0] eob_word;
  } record_cmd_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_release_t;

endpackage

/* rtl/tev_front.sv */
module tev_front #(
  parameter int unsigned MAX_CHANNELS = tev_pkg::MAX_CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tev_pkg::WORD_W-1:0]  fifo_word,
  input  logic                        end_of_read,
  input  logic                        q_full,
  output logic                        push,
  output tev_pkg::record_cmd_t        cmd,
  output tev_pkg::buf_wr_t            buf_wr,
  input  tev_pkg::bank_release_t      bank_free,
  output logic [1:0]                  bank_busy
);
  import tev_pkg::*;

  localparam count_t MAX_CNT = count_t'(MAX_CHANNELS);

  count_t     expected_count, expected_count_next;
  count_t     decoded_count, decoded_count_next;
  logic       in_event, in_event_next;
  logic       bank, bank_next;
  logic [1:0] bank_busy_next;
  logic       accept;
  logic [2:0] word_type;
  count_t     hdr_count;

  assign in_ready  = !q_full && !bank_busy[bank];
  assign accept    = in_valid && in_ready;
  assign word_type = fifo_word[26:24];
  assign hdr_count = fifo_word[13:8];

  assign cmd.bank     = bank;
  assign cmd.count    = decoded_count;
  assign cmd.eob_word = fifo_word;

  always_comb begin
    expected_count_next = expected_count;
    decoded_count_next  = decoded_count;
    in_event_next       = in_event;
    push                = 1'b0;
    buf_wr.en           = 1'b0;
    buf_wr.bank         = bank;
    buf_wr.idx          = decoded_count;
    buf_wr.data         = fifo_word;
    if (accept) begin
      unique case (word_type)
        TYPE_HEADER: begin
          decoded_count_next = '0;
          if (hdr_count > MAX_CNT) begin
            expected_count_next = '0;
            in_event_next       = 1'b0;
          end else begin
            expected_count_next = hdr_count;
            in_event_next       = 1'b1;
          end
        end
        TYPE_DATUM: begin
          if (in_event) begin
            if (decoded_count >= expected_count || decoded_count >= MAX_CNT) begin
              in_event_next = 1'b0;
            end else begin
              buf_wr.en          = 1'b1;
              decoded_count_next = decoded_count + count_t'(1);
            end
          end
        end
        TYPE_EOB: begin
          push          = in_event && (decoded_count == expected_count);
          in_event_next = 1'b0;
        end
        default: begin
          in_event_next = 1'b0;
        end
      endcase
      if (end_of_read) begin
        in_event_next = 1'b0;
      end
    end
  end

  // A bank is busy from the moment its record is queued until the back end
  // issues the record's location word.
  always_comb begin
    bank_next      = push ? !bank : bank;
    bank_busy_next = bank_busy;
    if (push) begin
      bank_busy_next[bank] = 1'b1;
    end
    if (bank_free.valid) begin
      bank_busy_next[bank_free.bank] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_count <= '0;
      decoded_count  <= '0;
      in_event       <= 1'b0;
      bank           <= 1'b0;
      bank_busy      <= '0;
    end else begin
      expected_count <= expected_count_next;
      decoded_count  <= decoded_count_next;
      in_event       <= in_event_next;
      bank           <= bank_next;
      bank_busy      <= bank_busy_next;
    end
  end

endmodule

/* rtl/tev_queue.sv */
module tev_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  tev_pkg::record_cmd_t  push_cmd,
  output logic                  full,
  input  logic                  pop,
  output logic                  empty,
  output tev_pkg::record_cmd_t  head
);
  import tev_pkg::*;

  localparam logic [QPTR_W:0] FULL_FILL = (QPTR_W+1)'(QUEUE_DEPTH);

  record_cmd_t       entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full  = (fill == FULL_FILL);
  assign empty = (fill == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

/* rtl/tev_back.sv */
module tev_back #(
  parameter int unsigned MAX_CHANNELS = tev_pkg::MAX_CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  tev_pkg::record_cmd_t         q_head,
  output logic                         pop,
  input  tev_pkg::buf_wr_t             buf_wr,
  input  logic [tev_pkg::WORD_W-1:0]   data_id,
  input  logic [tev_pkg::CRATE_W-1:0]  crate_number,
  input  logic [tev_pkg::SLOT_W-1:0]   slot_number,
  output tev_pkg::bank_release_t       bank_free,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tev_pkg::WORD_W-1:0]   record_word,
  output logic                         last_of_record
);
  import tev_pkg::*;

  localparam int unsigned BUF_DEPTH = 2 * MAX_CHANNELS;
  localparam int unsigned ADDR_W    = $clog2(BUF_DEPTH);

  typedef enum logic [2:0] {
    B_IDLE,
    B_FETCH,
    B_HOLD,
    B_EOB,
    B_ID,
    B_LOC
  } back_state_t;

  back_state_t       state;
  record_cmd_t       cur;
  count_t            idx;
  logic [WORD_W-1:0] buffer_mem [BUF_DEPTH];
  logic [WORD_W-1:0] rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              out_free;
  logic [WORD_W-1:0] id_word;
  logic [WORD_W-1:0] loc_word;

  // Bank one sits above bank zero; a written index is always below MAX_CHANNELS.
  function automatic logic [ADDR_W-1:0] buf_addr(input logic b, input count_t i);
    logic [ADDR_W-1:0] base;
    base = b ? ADDR_W'(MAX_CHANNELS) : '0;
    return base + ADDR_W'(i);
  endfunction

  assign rd_addr  = buf_addr(cur.bank, idx);
  assign wr_addr  = buf_addr(buf_wr.bank, buf_wr.idx);
  assign out_free = !out_valid || out_ready;
  assign pop      = (state == B_IDLE) && !q_empty;
  assign id_word  = data_id | (WORD_W'(cur.count) + WORD_W'(TRAILER_ADD));
  assign loc_word = {6'd0, crate_number[4:1], 1'b0, slot_number, 16'd0};

  always_ff @(posedge clk) begin
    if (buf_wr.en) begin
      buffer_mem[wr_addr] <= buf_wr.data;
    end
    rd_data <= buffer_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      bank_free <= '0;
    end else begin
      bank_free.valid <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            cur   <= q_head;
            idx   <= '0;
            state <= B_FETCH;
          end
        end
        B_FETCH: begin
          state <= (idx == cur.count) ? B_EOB : B_HOLD;
        end
        B_HOLD: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            record_word    <= rd_data;
            last_of_record <= 1'b0;
            idx            <= idx + count_t'(1);
            state          <= B_FETCH;
          end
        end
        B_EOB: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            record_word    <= cur.eob_word;
            last_of_record <= 1'b0;
            state          <= B_ID;
          end
        end
        B_ID: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            record_word    <= id_word;
            last_of_record <= 1'b0;
            state          <= B_LOC;
          end
        end
        B_LOC: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            record_word     <= loc_word;
            last_of_record  <= 1'b1;
            bank_free.valid <= 1'b1;
            bank_free.bank  <= cur.bank;
            state           <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/tdc_event_word_validator_unit.sv */
// Event-word validator for a TDC output buffer.
// The input channel (in_valid/in_ready) takes one raw buffer word per request
// with its end_of_read flag. Headers open an event, data words are stored in
// one of two buffer banks, and an end-of-block word whose data count matches
// the header queues the record. The output channel (out_valid/out_ready)
// then delivers the stored data words in order, the end-of-block word, the
// record header word (data_id ORed with count plus three) and the location
// word, which carries last_of_record. Mismatched events produce nothing.
// The configuration channel (cfg_valid/cfg_ready) is always ready and writes
// data_id, crate_number or slot_number by index; write it only while idle.
// Input words are taken one per cycle while in_ready is high. A queued record
// moves to the back end, which fetches each stored data word through the
// buffer read port and its registered read before issuing it, then issues
// the three closing words. Input stalls only while the bank it would fill
// is still queued or being drained, which the two banks and the two-entry
// record queue keep rare. When the receiver stalls, the output register holds
// its word and the drain waits; input keeps flowing into the free bank.
// Synchronous reset closes any open event, empties the queue, frees both
// banks and clears the configuration registers; no clearing pass is needed.
module tdc_event_word_validator_unit #(
  parameter int unsigned MAX_CHANNELS = tev_pkg::MAX_CHANNELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tev_pkg::WORD_W-1:0]     fifo_word,
  input  logic                           end_of_read,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tev_pkg::WORD_W-1:0]     record_word,
  output logic                           last_of_record,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tev_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tev_pkg::WORD_W-1:0]     cfg_data
);
  import tev_pkg::*;

  logic [WORD_W-1:0]  data_id;
  logic [CRATE_W-1:0] crate_number;
  logic [SLOT_W-1:0]  slot_number;

  logic          q_full;
  logic          q_empty;
  logic          push;
  logic          pop;
  record_cmd_t   cmd;
  record_cmd_t   q_head;
  buf_wr_t       buf_wr;
  bank_release_t bank_free;
  logic [1:0]    bank_busy;

  // Configuration registers. Writes to unused indexes are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_id      <= '0;
      crate_number <= '0;
      slot_number  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DATA_ID: data_id      <= cfg_data;
        CFG_CRATE:   crate_number <= cfg_data[CRATE_W-1:0];
        CFG_SLOT:    slot_number  <= cfg_data[SLOT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The front end classifies words and fills the buffer bank of the open event.
  tev_front #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .fifo_word  (fifo_word),
    .end_of_read(end_of_read),
    .q_full     (q_full),
    .push       (push),
    .cmd        (cmd),
    .buf_wr     (buf_wr),
    .bank_free  (bank_free),
    .bank_busy  (bank_busy)
  );

  // Completed records wait here until the back end takes them.
  tev_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(cmd),
    .full    (q_full),
    .pop     (pop),
    .empty   (q_empty),
    .head    (q_head)
  );

  // The back end owns the buffer memory and drains one record at a time.
  tev_back #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .pop           (pop),
    .buf_wr        (buf_wr),
    .data_id       (data_id),
    .crate_number  (crate_number),
    .slot_number   (slot_number),
    .bank_free     (bank_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .record_word   (record_word),
    .last_of_record(last_of_record)
  );

  // A data word must never land in a bank whose record is still draining.
  a_write_free_bank: assert property (@(posedge clk) disable iff (rst)
    buf_wr.en |-> !bank_busy[buf_wr.bank])
    else $error("buffer write into a bank that is being drained");

  // The back end only frees a bank that the front end marked busy.
  a_free_busy_bank: assert property (@(posedge clk) disable iff (rst)
    bank_free.valid |-> bank_busy[bank_free.bank])
    else $error("bank released that was not busy");

  // A record is queued only when the queue has room.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("record queued while the queue is full");

endmodule

/* tb/tev_record_checker.sv */
`timescale 1ns / 100ps

module tev_record_checker #(
  parameter int unsigned MAX_CHANNELS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [tev_pkg::WORD_W-1:0]    fifo_word,
  input  logic                          end_of_read,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [tev_pkg::WORD_W-1:0]    record_word,
  input  logic                          last_of_record,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [tev_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tev_pkg::WORD_W-1:0]    cfg_data,
  output int                            errors,
  output int                            outstanding,
  output int                            records_done,
  output int                            words_done
);
  import tev_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } record_beat_t;

  record_beat_t          record_words_due[$];
  logic [WORD_W-1:0]     stash [2**CNT_W];
  count_t                want_count;
  count_t                seen_count;
  logic                  event_open;
  logic [WORD_W-1:0]     data_id_reg;
  logic [CRATE_W-1:0]    crate_reg;
  logic [SLOT_W-1:0]     slot_reg;

  // Follows one buffer word through the event decoder and queues the record
  // words that a matching end-of-block word releases.
  task automatic decode_buffer_word(input logic [WORD_W-1:0] w, input logic eor);
    logic [2:0]        kind;
    count_t            cnt;
    logic [WORD_W-1:0] loc;
    count_t            i;
    kind = w[26:24];
    case (kind)
      TYPE_HEADER: begin
        cnt = w[13:8];
        seen_count = '0;
        if (cnt > MAX_CHANNELS) begin
          want_count = '0;
          event_open = 1'b0;
        end else begin
          want_count = cnt;
          event_open = 1'b1;
        end
      end
      TYPE_DATUM: begin
        if (event_open) begin
          if (seen_count >= want_count || seen_count >= MAX_CHANNELS) begin
            event_open = 1'b0;
          end else begin
            stash[seen_count] = w;
            seen_count = seen_count + 1'b1;
          end
        end
      end
      TYPE_EOB: begin
        if (event_open && seen_count == want_count) begin
          loc = '0;
          loc[25:22] = crate_reg[4:1];
          loc[20:16] = slot_reg;
          for (i = '0; i < seen_count; i++) begin
            record_words_due.push_back('{word: stash[i], last: 1'b0});
          end
          record_words_due.push_back('{word: w, last: 1'b0});
          record_words_due.push_back('{word: data_id_reg | (WORD_W'(want_count) + TRAILER_ADD),
                                       last: 1'b0});
          record_words_due.push_back('{word: loc, last: 1'b1});
          records_done++;
        end
        event_open = 1'b0;
      end
      default: begin
        event_open = 1'b0;
      end
    endcase
    if (eor) begin
      event_open = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    record_beat_t due;
    if (rst) begin
      record_words_due.delete();
      want_count   = '0;
      seen_count   = '0;
      event_open   = 1'b0;
      data_id_reg  = '0;
      crate_reg    = '0;
      slot_reg     = '0;
      errors       = 0;
      records_done = 0;
      words_done   = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DATA_ID: data_id_reg = cfg_data;
          CFG_CRATE:   crate_reg = cfg_data[CRATE_W-1:0];
          CFG_SLOT:    slot_reg = cfg_data[SLOT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        decode_buffer_word(fifo_word, end_of_read);
      end
      if (out_valid && out_ready) begin
        words_done++;
        if (record_words_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected record word: expected none, actual %h last %b",
                   $time, record_word, last_of_record);
        end else begin
          due = record_words_due.pop_front();
          if (record_word !== due.word) begin
            errors++;
            $display("%0t: record_word mismatch: expected %h, actual %h",
                     $time, due.word, record_word);
          end
          if (last_of_record !== due.last) begin
            errors++;
            $display("%0t: last_of_record mismatch: expected %b, actual %b",
                     $time, due.last, last_of_record);
          end
        end
      end
    end
    outstanding = record_words_due.size();
  end

endmodule

/* tb/tdc_event_word_validator_unit_test.sv */
`timescale 1ns / 100ps

module tdc_event_word_validator_unit_test;
  import tev_pkg::*;

  // The block is built for the usual 32-channel converter; the checker is
  // given the same size so that both agree on what counts as oversized.
  localparam int unsigned MAX_CH = 32;

  // Cycle budget for the whole run, with room for many times the worst stalls.
  localparam int unsigned LIMIT = 200000;

  // Cycles allowed after the last record word before a phase counts as idle.
  localparam int unsigned SETTLE = 16;

  // Length of the deliberate receiver hold-off, in cycles.
  localparam int unsigned HOLD_CYCLES = 300;

  // Index 3 names no register; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_SLOT + 1'b1;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [WORD_W-1:0]    fifo_word;
  logic                 end_of_read;
  logic                 out_valid;
  logic                 out_ready;
  logic [WORD_W-1:0]    record_word;
  logic                 last_of_record;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  int errors;
  int outstanding;
  int records_done;
  int words_done;

  int unsigned sent_words = 0;
  int unsigned cfg_writes = 0;
  int unsigned cycle_count = 0;

  // When calm is set neither side idles; hold_request asks the receiver for
  // one long hold-off, which it then times on its own.
  bit calm = 1'b0;
  bit hold_request = 1'b0;
  bit hold_taken = 1'b0;

  always #4 clk = ~clk;

  tdc_event_word_validator_unit #(
    .MAX_CHANNELS(MAX_CH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .fifo_word     (fifo_word),
    .end_of_read   (end_of_read),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .record_word   (record_word),
    .last_of_record(last_of_record),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // The checker watches all three channels, predicts every record word and
  // compares what comes out; this module only drives and judges.
  tev_record_checker #(
    .MAX_CHANNELS(MAX_CH)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .fifo_word     (fifo_word),
    .end_of_read   (end_of_read),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .record_word   (record_word),
    .last_of_record(last_of_record),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .outstanding   (outstanding),
    .records_done  (records_done),
    .words_done    (words_done)
  );

  // Watchdog: a hung handshake must not keep the run alive forever.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Timeout after %0d cycles with %0d record words still due.",
               LIMIT, outstanding);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver side. It drops out_ready about 17 times in a hundred, never
  // while calm is set, and once on request holds off for HOLD_CYCLES so
  // that both banks and the record queue fill and the input stalls.
  initial begin : receiver
    int unsigned held;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) begin
          @(negedge clk);
        end
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 17);
      end
    end
  end

  // Builds a buffer word of the given type. Bits other than the type code
  // (and the channel count, for a header) come from fill.
  function automatic logic [WORD_W-1:0] make_word(input logic [2:0] kind,
                                                  input count_t cnt,
                                                  input logic [WORD_W-1:0] fill);
    logic [WORD_W-1:0] w;
    w = fill;
    w[26:24] = kind;
    if (kind == TYPE_HEADER) begin
      w[13:8] = cnt;
    end
    return w;
  endfunction

  // Offers one buffer word. Called at a falling edge; returns at the falling
  // edge after the request was taken. Random gaps come before the word, so
  // in_valid never drops while a word is being offered.
  task automatic send_request(input logic [WORD_W-1:0] w, input logic eor);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    fifo_word   <= w;
    end_of_read <= eor;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    sent_words++;
    @(negedge clk);
  endtask

  // Writes one configuration register. The caller lowers cfg_valid after
  // its last write, so back-to-back writes keep it high.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [WORD_W-1:0] id, input logic [CRATE_W-1:0] crate,
                            input logic [SLOT_W-1:0] slot);
    write_reg(CFG_DATA_ID, id);
    write_reg(CFG_CRATE, WORD_W'(crate));
    write_reg(CFG_SLOT, WORD_W'(slot));
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Stops offering words and waits until every predicted record word has
  // come back, plus a margin for words that produce nothing.
  task automatic drain_phase();
    in_valid <= 1'b0;
    while (outstanding != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  // One event: a header, its data words and an end-of-block word. Most are
  // well formed; the rest carry one flaw each: a wrong number of data words,
  // a stray word of an undefined type, an oversized header, an earlier
  // header that gets restarted, or an end-of-read flag before the end.
  task automatic send_event(input bit widest);
    count_t      cnt;
    int unsigned flaw;
    int unsigned n;
    int unsigned k;
    int unsigned cut;
    bit          short_data;
    bit          bad_type;
    bit          early_eor;
    logic [2:0]  junk;
    cnt  = widest ? count_t'(MAX_CH) : count_t'($urandom_range(6));
    flaw = $urandom_range(99);
    short_data = (flaw >= 70 && flaw < 78);
    bad_type   = (flaw >= 78 && flaw < 84);
    early_eor  = (flaw >= 94);

    if (flaw >= 84 && flaw < 89) begin
      // Oversized channel count: nothing may come out of this event.
      send_request(make_word(TYPE_HEADER, count_t'($urandom_range(63, MAX_CH + 1)), $urandom),
                   1'b0);
      n = $urandom_range(3);
      for (k = 0; k < n; k++) begin
        send_request(make_word(TYPE_DATUM, '0, $urandom), 1'b0);
      end
      send_request(make_word(TYPE_EOB, '0, $urandom), 1'b0);
      return;
    end

    if (flaw >= 89 && flaw < 94) begin
      // An abandoned event that the next header restarts.
      send_request(make_word(TYPE_HEADER, count_t'($urandom_range(8)), $urandom), 1'b0);
      n = $urandom_range(2);
      for (k = 0; k < n; k++) begin
        send_request(make_word(TYPE_DATUM, '0, $urandom), 1'b0);
      end
    end

    n = cnt;
    if (short_data) begin
      n = (cnt == 0 || $urandom_range(1)) ? cnt + 1 : cnt - 1;
    end
    cut = $urandom_range(n);

    send_request(make_word(TYPE_HEADER, cnt, $urandom), early_eor && cut == 0);
    for (k = 0; k <= n; k++) begin
      if (bad_type && k == cut) begin
        do begin
          junk = 3'($urandom_range(7));
        end while (junk == TYPE_DATUM || junk == TYPE_HEADER || junk == TYPE_EOB);
        send_request(make_word(junk, '0, $urandom), 1'b0);
      end
      if (k < n) begin
        send_request(make_word(TYPE_DATUM, '0, $urandom), early_eor && cut == k + 1);
      end
    end
    // An end-of-read flag on the end-of-block word comes after the record
    // has been decided, so it must not suppress it.
    send_request(make_word(TYPE_EOB, '0, $urandom), $urandom_range(9) == 0);
  endtask

  // Random phase: each starts with a full 32-channel event, then mixes
  // events with a little raw noise until the word quota is met.
  task automatic run_random(input int unsigned quota);
    int unsigned goal;
    goal = sent_words + quota;
    send_event(1'b1);
    while (sent_words < goal) begin
      if ($urandom_range(99) < 6) begin
        send_request($urandom, 1'($urandom_range(1)));
      end else begin
        send_event($urandom_range(99) < 3);
      end
    end
  endtask

  initial begin : stimulus
    rst         = 1'b1;
    in_valid    = 1'b0;
    fifo_word   = '0;
    end_of_read = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_DATA_ID;
    cfg_data    = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed phase with every register at its top value. The write to
    // the spare index comes first and must leave the others untouched.
    write_reg(CFG_SPARE, $urandom);
    set_config('1, '1, '1);

    // End-of-block and datum words with no event open: no output.
    send_request(make_word(TYPE_EOB, '0, '1), 1'b0);
    send_request(make_word(TYPE_DATUM, '0, '0), 1'b0);
    // Empty event: only the closing three words come out.
    send_request(make_word(TYPE_HEADER, 6'd0, '0), 1'b0);
    send_request(make_word(TYPE_EOB, '0, '1), 1'b0);
    // Largest count the header field holds is above the limit: dropped.
    send_request(make_word(TYPE_HEADER, 6'd63, '1), 1'b0);
    send_request(make_word(TYPE_EOB, '0, '0), 1'b0);
    // A second header restarts the event, which then completes.
    send_request(make_word(TYPE_HEADER, 6'd1, '0), 1'b0);
    send_request(make_word(TYPE_HEADER, 6'd1, '1), 1'b0);
    send_request(make_word(TYPE_DATUM, '0, '1), 1'b0);
    send_request(make_word(TYPE_EOB, '0, '0), 1'b0);
    // One datum more than the header announced: dropped.
    send_request(make_word(TYPE_HEADER, 6'd1, '0), 1'b0);
    send_request(make_word(TYPE_DATUM, '0, '0), 1'b0);
    send_request(make_word(TYPE_DATUM, '0, '1), 1'b0);
    send_request(make_word(TYPE_EOB, '0, '1), 1'b0);
    // One datum short: the count check at end of block drops it.
    send_request(make_word(TYPE_HEADER, 6'd2, '1), 1'b0);
    send_request(make_word(TYPE_DATUM, '0, '1), 1'b0);
    send_request(make_word(TYPE_EOB, '0, '1), 1'b0);
    // An undefined type code inside an event drops it.
    send_request(make_word(TYPE_HEADER, 6'd1, '0), 1'b0);
    send_request(make_word(~TYPE_DATUM, '0, '1), 1'b0);
    send_request(make_word(TYPE_EOB, '0, '0), 1'b0);
    // End of read right after the header closes the event.
    send_request(make_word(TYPE_HEADER, 6'd1, '0), 1'b1);
    send_request(make_word(TYPE_DATUM, '0, '0), 1'b0);
    send_request(make_word(TYPE_EOB, '0, '0), 1'b0);
    // End of read on the end-of-block word still lets the record out.
    send_request(make_word(TYPE_HEADER, 6'd1, '1), 1'b0);
    send_request(make_word(TYPE_DATUM, '0, '1), 1'b0);
    send_request(make_word(TYPE_EOB, '0, '1), 1'b1);
    drain_phase();

    // Random phases. The first uses the all-zero settings, the second runs
    // with no idling on either side, the third includes the long receiver
    // hold-off, and the last uses fresh random settings.
    set_config('0, '0, '0);
    run_random(110);
    drain_phase();

    set_config($urandom, 5'($urandom), 5'($urandom));
    calm = 1'b1;
    run_random(110);
    drain_phase();
    calm = 1'b0;

    set_config($urandom, 5'($urandom), 5'($urandom));
    hold_request = 1'b1;
    run_random(110);
    drain_phase();

    set_config($urandom, 5'($urandom), 5'($urandom));
    run_random(110);
    drain_phase();

    $display("Run covered %0d buffer words in five phases with %0d register writes,",
             sent_words, cfg_writes);
    $display("and %0d records (%0d words) came back, one phase under a %0d-cycle hold-off.",
             records_done, words_done, HOLD_CYCLES);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
